/* rtl/gaussian_blur_3x3_top_defines.svh */
// ---------------------------------------------------------------------------
// gaussian_blur_3x3_top_defines.svh
// assertion macros for the 3x3 blur block, empty in synthesis
// ---------------------------------------------------------------------------
`ifndef GAUSSIAN_BLUR_3X3_TOP_DEFINES_SVH
`define GAUSSIAN_BLUR_3X3_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication on clk_i, off during reset
`define GB3_ASSERT_HOLDS(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gb3 assertion failed");
// next-cycle implication on clk_i, off during reset
`define GB3_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gb3 assertion failed");
`else
`define GB3_ASSERT_HOLDS(label, ante, cons)
`define GB3_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* rtl/gb3_pkg.sv */
// ---------------------------------------------------------------------------
// gb3_pkg
// shared types, constants and kernel weights of the 3x3 blur block
// ---------------------------------------------------------------------------
package gb3_pkg;

  localparam int PixW     = 8;
  localparam int Lanes    = 3;
  localparam int PackW    = Lanes * PixW;
  localparam int SumW     = 12;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 11;

  localparam int MaxWidthDef  = 1024;
  localparam int MaxHeightDef = 1024;

  // binomial kernel, row-major, left column first
  localparam logic [8:0][2:0] Weight = {3'd1, 3'd2, 3'd1,
                                        3'd2, 3'd4, 3'd2,
                                        3'd1, 3'd2, 3'd1};

  typedef enum logic [CfgIdxW-1:0] {
    CfgFrameWidth  = 2'd0,
    CfgFrameHeight = 2'd1,
    CfgPackedMode  = 2'd2
  } cfg_idx_e;

  // three lanes, lane 0 in the low byte
  typedef logic [PackW-1:0] pack_t;

  // 3x3 neighborhood, index row*3 + column
  typedef logic [8:0][PackW-1:0] taps_t;

  typedef struct packed {
    logic            req_type;
    logic [PixW-1:0] pixel_lane0;
    logic [PixW-1:0] pixel_lane1;
    logic [PixW-1:0] pixel_lane2;
  } in_item_t;

  typedef struct packed {
    logic [PixW-1:0] blur_lane0;
    logic [PixW-1:0] blur_lane1;
    logic [PixW-1:0] blur_lane2;
    logic            frame_last;
  } out_item_t;

  // window control from the stage register
  typedef struct packed {
    logic advance;
    logic clear;
    logic col_zero;
    logic col_ge2;
    logic width_ge2;
    logic row_ge1;
    logic row_ge2;
    logic row_odd;
  } win_ctrl_t;

endpackage

/* rtl/gb3_stream_if.sv */
// ---------------------------------------------------------------------------
// gb3_stream_if
// valid/ready stream channel carrying one item per transfer
// ---------------------------------------------------------------------------
interface gb3_stream_if #(
  parameter type item_t = logic
) ();

  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

/* rtl/gb3_line_buf.sv */
// ---------------------------------------------------------------------------
// gb3_line_buf
// two row stores split by row parity, one write and one registered read each
// ---------------------------------------------------------------------------
module gb3_line_buf #(
  parameter int  MAX_WIDTH = gb3_pkg::MaxWidthDef,
  localparam int AW        = $clog2(MAX_WIDTH)
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [AW-1:0]        addr_i,
  input  logic                 odd_i,
  input  gb3_pkg::pack_t       wr_data_i,
  output gb3_pkg::pack_t       rd_even_o,
  output gb3_pkg::pack_t       rd_odd_o
);
  import gb3_pkg::*;

  pack_t mem_even [MAX_WIDTH];
  pack_t mem_odd  [MAX_WIDTH];
  pack_t rd_even_q;
  pack_t rd_odd_q;

  // read returns the old entry when the same column is written
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (odd_i) begin
        mem_odd[addr_i] <= wr_data_i;
      end else begin
        mem_even[addr_i] <= wr_data_i;
      end
      rd_even_q <= mem_even[addr_i];
      rd_odd_q  <= mem_odd[addr_i];
    end
  end

  assign rd_even_o = rd_even_q;
  assign rd_odd_o  = rd_odd_q;

endmodule

/* rtl/gb3_window.sv */
// ---------------------------------------------------------------------------
// gb3_window
// column window registers and 3x3 tap selection with edge padding
// ---------------------------------------------------------------------------
module gb3_window (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gb3_pkg::win_ctrl_t ctrl_i,
  input  gb3_pkg::pack_t     rd_even_i,
  input  gb3_pkg::pack_t     rd_odd_i,
  input  gb3_pkg::pack_t     px_i,
  output gb3_pkg::taps_t     taps_o
);
  import gb3_pkg::*;

  // per row: slot 0 older column, slot 1 newer column
  logic [2:0][1:0][PackW-1:0] win_q, win_d;
  pack_t [2:0]                new_col;
  logic                       use_left;

  // rows above the frame read as zero
  always_comb begin
    new_col[0] = '0;
    new_col[1] = '0;
    if (ctrl_i.row_ge2) begin
      new_col[0] = ctrl_i.row_odd ? rd_odd_i : rd_even_i;
    end
    if (ctrl_i.row_ge1) begin
      new_col[1] = ctrl_i.row_odd ? rd_even_i : rd_odd_i;
    end
    new_col[2] = px_i;
  end

  // at column zero the center is the last column of the row before
  assign use_left = ctrl_i.col_zero ? ctrl_i.width_ge2 : ctrl_i.col_ge2;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      taps_o[k*3]     = use_left ? win_q[k][0] : '0;
      taps_o[k*3 + 1] = win_q[k][1];
      taps_o[k*3 + 2] = ctrl_i.col_zero ? '0 : new_col[k];
    end
  end

  // shift in the new column, clear at frame end or reconfiguration
  always_comb begin
    win_d = win_q;
    if (ctrl_i.clear) begin
      win_d = '0;
    end else if (ctrl_i.advance) begin
      for (int k = 0; k < 3; k++) begin
        win_d[k][0] = win_q[k][1];
        win_d[k][1] = new_col[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else begin
      win_q <= win_d;
    end
  end

endmodule

/* rtl/gb3_blur.sv */
// ---------------------------------------------------------------------------
// gb3_blur
// binomial 3x3 weighted sum per lane with round half up
// ---------------------------------------------------------------------------
module gb3_blur (
  input  gb3_pkg::taps_t                                  taps_i,
  output logic [gb3_pkg::Lanes-1:0][gb3_pkg::PixW-1:0]    blur_o
);
  import gb3_pkg::*;

  logic [Lanes-1:0][SumW-1:0] sum;
  logic [Lanes-1:0][SumW-1:0] rnd;

  // sum peaks at 16*255, so the rounded value never needs a clamp
  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      sum[l] = '0;
      for (int k = 0; k < 9; k++) begin
        sum[l] = sum[l] + SumW'(Weight[k]) * SumW'(taps_i[k][l*PixW +: PixW]);
      end
      rnd[l]    = sum[l] + SumW'(8);
      blur_o[l] = rnd[l][SumW-1:4];
    end
  end

endmodule

/* rtl/gaussian_blur_3x3_top.sv */
// ---------------------------------------------------------------------------
// gaussian_blur_3x3_top
// 3x3 binomial blur of a raster pixel stream with zero padding
// ---------------------------------------------------------------------------
// One item is taken every clock while the output does not stall. An accepted
// item reads the two row stores at its column and enters the stage register;
// as it advances, the window shifts, the kernel sums and the result lands in
// the output register; without stalls the rate is one item per cycle, set by
// the single read and write port of each row store. Output (i,j) follows item
// (i+1)*width+j+1, so a frame takes width*height+width+1 items; drain items
// stand in for the trailing zero pixels and a drain with no frame in progress
// is dropped. Row stores hold no reset state and need no clearing pass: rows
// above the frame are masked to zero. Any register write aborts the frame.
`include "gaussian_blur_3x3_top_defines.svh"

module gaussian_blur_3x3_top #(
  parameter int MAX_WIDTH  = gb3_pkg::MaxWidthDef,
  parameter int MAX_HEIGHT = gb3_pkg::MaxHeightDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [gb3_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [gb3_pkg::CfgDataW-1:0]  cfg_data_i,
  gb3_stream_if.sink                    in_i,
  gb3_stream_if.source                  out_o
);
  import gb3_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WEW = $clog2(MAX_WIDTH + 1);
  localparam int RW  = $clog2(MAX_HEIGHT + 2);
  localparam int HEW = $clog2(MAX_HEIGHT + 1);

  typedef struct packed {
    logic emit;
    logic last;
    logic col_zero;
    logic col_ge2;
    logic row_ge1;
    logic row_ge2;
    logic row_odd;
  } stage_t;

  logic [WEW-1:0] w_eff_q;
  logic [HEW-1:0] h_eff_q;
  logic           packed_q;
  logic           cfg_hit;

  logic [CW-1:0]  c_q, c_d;
  logic [RW-1:0]  r_q, r_d;
  logic [WEW-1:0] c_inc;

  in_item_t       item;
  logic           in_ready;
  logic           take;
  logic           pix_ok;
  pack_t          px;
  stage_t         s0;

  logic           s1_valid_q;
  stage_t         s1_q;
  pack_t          s1_px_q;
  logic           s1_adv;

  pack_t          rd_even, rd_odd;
  win_ctrl_t      win_ctrl;
  taps_t          taps;
  logic [Lanes-1:0][PixW-1:0] blur;

  logic           out_valid_q;
  out_item_t      out_data_q;

  // configuration registers, stored already clamped
  always_comb begin
    case (cfg_idx_e'(cfg_idx_i))
      CfgFrameWidth:  cfg_hit = cfg_we_i;
      CfgFrameHeight: cfg_hit = cfg_we_i;
      CfgPackedMode:  cfg_hit = cfg_we_i;
      default:        cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_eff_q  <= WEW'(1);
      h_eff_q  <= HEW'(1);
      packed_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgFrameWidth: begin
          if (cfg_data_i == '0) begin
            w_eff_q <= WEW'(1);
          end else if (32'(cfg_data_i) > 32'(MAX_WIDTH)) begin
            w_eff_q <= WEW'(MAX_WIDTH);
          end else begin
            w_eff_q <= WEW'(cfg_data_i);
          end
        end
        CfgFrameHeight: begin
          if (cfg_data_i == '0) begin
            h_eff_q <= HEW'(1);
          end else if (32'(cfg_data_i) > 32'(MAX_HEIGHT)) begin
            h_eff_q <= HEW'(MAX_HEIGHT);
          end else begin
            h_eff_q <= HEW'(cfg_data_i);
          end
        end
        CfgPackedMode: packed_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // input decode: drop idle drains, zero pixels past the last row
  assign item     = in_i.data;
  assign in_ready = !s1_valid_q || s1_adv;
  assign take     = in_i.valid && in_ready &&
                    !(item.req_type && (r_q == '0) && (c_q == '0));
  assign pix_ok   = !item.req_type && (r_q < RW'(h_eff_q));

  always_comb begin
    px = '0;
    if (pix_ok) begin
      px[PixW-1:0] = item.pixel_lane0;
      if (packed_q) begin
        px[2*PixW-1:PixW]   = item.pixel_lane1;
        px[3*PixW-1:2*PixW] = item.pixel_lane2;
      end
    end
  end

  // position flags of the item being taken
  always_comb begin
    s0.row_ge1  = r_q >= RW'(1);
    s0.row_ge2  = r_q >= RW'(2);
    s0.row_odd  = r_q[0];
    s0.col_zero = c_q == '0;
    s0.col_ge2  = c_q >= CW'(2);
    s0.emit     = s0.row_ge2 || (r_q == RW'(1) && !s0.col_zero);
    s0.last     = s0.col_zero && (r_q == RW'(h_eff_q) + RW'(1));
  end

  // raster counters
  assign c_inc = WEW'(c_q) + WEW'(1);

  always_comb begin
    c_d = c_q;
    r_d = r_q;
    if (cfg_hit) begin
      c_d = '0;
      r_d = '0;
    end else if (take) begin
      if (s0.last) begin
        c_d = '0;
        r_d = '0;
      end else if (c_inc == w_eff_q) begin
        c_d = '0;
        r_d = r_q + RW'(1);
      end else begin
        c_d = CW'(c_inc);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q <= '0;
      r_q <= '0;
    end else begin
      c_q <= c_d;
      r_q <= r_d;
    end
  end

  // row stores, read and written at the column of the item
  gb3_line_buf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_buf (
    .clk_i     (clk_i),
    .en_i      (take),
    .addr_i    (c_q),
    .odd_i     (r_q[0]),
    .wr_data_i (px),
    .rd_even_o (rd_even),
    .rd_odd_o  (rd_odd)
  );

  // stage register
  assign s1_adv = s1_valid_q && (!out_valid_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (take) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_q    <= s0;
      s1_px_q <= px;
    end
  end

  // window and kernel
  always_comb begin
    win_ctrl.advance   = s1_adv;
    win_ctrl.clear     = cfg_hit || (s1_adv && s1_q.last);
    win_ctrl.col_zero  = s1_q.col_zero;
    win_ctrl.col_ge2   = s1_q.col_ge2;
    win_ctrl.width_ge2 = w_eff_q != WEW'(1);
    win_ctrl.row_ge1   = s1_q.row_ge1;
    win_ctrl.row_ge2   = s1_q.row_ge2;
    win_ctrl.row_odd   = s1_q.row_odd;
  end

  gb3_window u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (win_ctrl),
    .rd_even_i (rd_even),
    .rd_odd_i  (rd_odd),
    .px_i      (s1_px_q),
    .taps_o    (taps)
  );

  gb3_blur u_blur (
    .taps_i (taps),
    .blur_o (blur)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_q.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_q.emit) begin
      out_data_q.blur_lane0 <= blur[0];
      out_data_q.blur_lane1 <= blur[1];
      out_data_q.blur_lane2 <= blur[2];
      out_data_q.frame_last <= s1_q.last;
    end
  end

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // checks
  `GB3_ASSERT_NEXT(a_last_clears_counters, take && s0.last, (r_q == '0) && (c_q == '0))
  `GB3_ASSERT_NEXT(a_emit_fills_output, s1_adv && s1_q.emit,
                   out_valid_q && (out_data_q.frame_last == $past(s1_q.last)))
  `GB3_ASSERT_HOLDS(a_column_in_row, 1'b1, WEW'(c_q) < w_eff_q)
  `GB3_ASSERT_HOLDS(a_row_in_frame, 1'b1, r_q <= RW'(h_eff_q) + RW'(1))

endmodule

/* verif/gaussian_blur_3x3_checker.sv */
// ---------------------------------------------------------------------------
// gaussian_blur_3x3_checker
// watches the pixel and blur channels, predicts each blurred pixel and
// compares it field by field with what the block hands out
// ---------------------------------------------------------------------------
module gaussian_blur_3x3_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [gb3_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [gb3_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  gb3_pkg::in_item_t            in_data_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  gb3_pkg::out_item_t           out_data_i,
  output int                           pending_o,
  output int                           fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import gb3_pkg::*;

  localparam int unsigned RowSpan  = MaxWidthDef;
  localparam int unsigned RowLimit = MaxHeightDef;
  // keep the log short when things go badly wrong
  localparam int ReportMax = 50;

  // shadow of the block: two line stores by row parity, window, counters
  pack_t               line_mem [2*RowSpan];
  taps_t               win;
  int unsigned         col_pos;
  int unsigned         row_pos;
  int unsigned         emitted;
  logic [CfgDataW-1:0] width_reg;
  logic [CfgDataW-1:0] height_reg;
  logic                packed_reg;

  out_item_t pending_blurs [$];
  int        mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic report_mismatch(input string msg);
    if (mismatches < ReportMax) $display("%0t ns blur check: %s", $time, msg);
    mismatches++;
  endtask

  function automatic int unsigned clamp_size(input logic [CfgDataW-1:0] v,
                                             input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  function automatic void clear_frame();
    col_pos = 0;
    row_pos = 0;
    emitted = 0;
    win     = '0;
  endfunction

  // any register write aborts the frame in progress
  function automatic void load_register(input logic [CfgIdxW-1:0] idx,
                                        input logic [CfgDataW-1:0] data);
    case (cfg_idx_e'(idx))
      CfgFrameWidth: begin
        width_reg = data;
      end
      CfgFrameHeight: begin
        height_reg = data;
      end
      CfgPackedMode: begin
        packed_reg = data[0];
      end
      default: begin
        return;
      end
    endcase
    clear_frame();
  endfunction

  // 1-2-1 by 1-2-1 weighted sum per lane, rounded half up and clamped
  function automatic out_item_t kernel_blur(input taps_t t);
    int unsigned acc;
    logic [7:0]  lane_val [3];
    out_item_t   o;
    for (int lane = 0; lane < 3; lane++) begin
      acc = 0;
      for (int k = 0; k < 9; k++) begin
        acc += ((k % 3 == 1) ? 2 : 1) * ((k / 3 == 1) ? 2 : 1) * t[k][8*lane +: 8];
      end
      acc = (acc + 8) >> 4;
      if (acc > 255) acc = 255;
      lane_val[lane] = acc[7:0];
    end
    o.blur_lane0 = lane_val[0];
    o.blur_lane1 = lane_val[1];
    o.blur_lane2 = lane_val[2];
    o.frame_last = 1'b0;
    return o;
  endfunction

  // one pixel in, at most one blurred pixel out
  function automatic bit predict_blur(input in_item_t it, output out_item_t res);
    int unsigned wd;
    int unsigned ht;
    int unsigned r;
    int unsigned c;
    pack_t       px;
    pack_t       top;
    pack_t       mid;
    taps_t       t;
    bit          emit;
    res  = '0;
    t    = '0;
    emit = 1'b0;
    wd   = clamp_size(width_reg, RowSpan);
    ht   = clamp_size(height_reg, RowLimit);
    r    = row_pos;
    c    = col_pos;

    // drain with no frame open is dropped
    if (it.req_type && r == 0 && c == 0 && emitted == 0) return 1'b0;

    // drains and rows past the frame read as zero pixels
    px = '0;
    if (!it.req_type && r < ht) begin
      px[7:0] = it.pixel_lane0;
      if (packed_reg) begin
        px[15:8]  = it.pixel_lane1;
        px[23:16] = it.pixel_lane2;
      end
    end

    // rows above the frame are masked
    top = (r >= 2) ? line_mem[(r % 2)*RowSpan + c] : '0;
    mid = (r >= 1) ? line_mem[((r + 1) % 2)*RowSpan + c] : '0;
    line_mem[(r % 2)*RowSpan + c] = px;

    // column zero finishes the last pixel of the row before, from the old window
    if (r >= 2 || (r == 1 && c >= 1)) begin
      emit = 1'b1;
      if (c == 0) begin
        for (int k = 0; k < 3; k++) begin
          t[k*3]     = (wd >= 2) ? win[k*3+1] : '0;
          t[k*3 + 1] = win[k*3+2];
          t[k*3 + 2] = '0;
        end
      end
    end

    // shift the window one column
    for (int k = 0; k < 3; k++) begin
      win[k*3]     = win[k*3+1];
      win[k*3 + 1] = win[k*3+2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = px;

    if (emit && c != 0) begin
      for (int k = 0; k < 3; k++) begin
        t[k*3]     = (c >= 2) ? win[k*3] : '0;
        t[k*3 + 1] = win[k*3+1];
        t[k*3 + 2] = win[k*3+2];
      end
    end

    c++;
    if (c >= wd) begin
      c = 0;
      r++;
    end
    col_pos = c;
    row_pos = r;

    if (!emit) return 1'b0;
    res = kernel_blur(t);
    emitted++;
    if (emitted >= wd*ht) begin
      res.frame_last = 1'b1;
      clear_frame();
    end
    return 1'b1;
  endfunction

  task automatic check_blur(input out_item_t got);
    out_item_t want;
    if (pending_blurs.size() == 0) begin
      report_mismatch($sformatf("blurred pixel %h/%h/%h last %b with none pending",
                                got.blur_lane0, got.blur_lane1, got.blur_lane2,
                                got.frame_last));
      return;
    end
    want = pending_blurs.pop_front();
    if (got.blur_lane0 !== want.blur_lane0)
      report_mismatch($sformatf("blur_lane0 got %h want %h", got.blur_lane0,
                                want.blur_lane0));
    if (got.blur_lane1 !== want.blur_lane1)
      report_mismatch($sformatf("blur_lane1 got %h want %h", got.blur_lane1,
                                want.blur_lane1));
    if (got.blur_lane2 !== want.blur_lane2)
      report_mismatch($sformatf("blur_lane2 got %h want %h", got.blur_lane2,
                                want.blur_lane2));
    if (got.frame_last !== want.frame_last)
      report_mismatch($sformatf("frame_last got %b want %b", got.frame_last,
                                want.frame_last));
  endtask

  // register writes, pixel transfers and blur transfers at each edge
  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_item_t blur_res;
    if (!rst_ni) begin
      width_reg  = CfgDataW'(1);
      height_reg = CfgDataW'(1);
      packed_reg = 1'b0;
      clear_frame();
      pending_blurs.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) load_register(cfg_idx_i, cfg_data_i);
      if (in_valid_i && in_ready_i) begin
        if (predict_blur(in_data_i, blur_res)) pending_blurs.push_back(blur_res);
      end
      if (out_valid_i && out_ready_i) check_blur(out_data_i);
      pending_o <= pending_blurs.size();
    end
  end

endmodule

/* verif/gaussian_blur_3x3_top_tb.sv */
// ---------------------------------------------------------------------------
// gaussian_blur_3x3_top_tb
// streams raster frames of many sizes and both lane modes through the blur
// block under random idling and long output stalls; a checker beside the
// block predicts every blurred pixel and counts mismatches
// ---------------------------------------------------------------------------
module gaussian_blur_3x3_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gb3_pkg::*;

  localparam int HoldCycles = 300;
  // longest prefix streamed from a frame that is cut off
  localparam int unsigned CutMax = 48;

  logic                clk_i  = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  int tx_idle_pct = 12;
  int rx_idle_pct = 58;
  int hold_asked  = 0;
  int pending;
  int fail_count;

  gb3_stream_if #(.item_t(in_item_t))  pix_ch ();
  gb3_stream_if #(.item_t(out_item_t)) blur_ch ();

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  gaussian_blur_3x3_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (pix_ch),
    .out_o      (blur_ch)
  );

  gaussian_blur_3x3_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (pix_ch.valid),
    .in_ready_i   (pix_ch.ready),
    .in_data_i    (pix_ch.data),
    .out_valid_i  (blur_ch.valid),
    .out_ready_i  (blur_ch.ready),
    .out_data_i   (blur_ch.data),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  function automatic in_item_t mk_item(input logic rt, input logic [7:0] a,
                                       input logic [7:0] b, input logic [7:0] c);
    in_item_t it;
    it.req_type    = rt;
    it.pixel_lane0 = a;
    it.pixel_lane1 = b;
    it.pixel_lane2 = c;
    return it;
  endfunction

  // samples lean on the extremes
  function automatic logic [7:0] pick_sample();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // one pixel transfer, with random idle cycles ahead of it
  task automatic send_pixel(input in_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      pix_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.data  <= it;
    @(posedge clk_i);
    while (!pix_ch.ready) @(posedge clk_i);
  endtask

  // wait until every blurred pixel is in, then let the pipeline settle
  task automatic finish_phase();
    pix_ch.valid <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic program_frame(input int unsigned w, input int unsigned h, input bit pk);
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgFrameWidth;
    cfg_data <= CfgDataW'(w);
    @(posedge clk_i);
    cfg_idx  <= CfgFrameHeight;
    cfg_data <= CfgDataW'(h);
    @(posedge clk_i);
    cfg_idx  <= CfgPackedMode;
    cfg_data <= CfgDataW'(pk);
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  // a full frame of random pixels plus its trailing drains, or a cut-off prefix
  task automatic stream_frame(input int unsigned w_set, input int unsigned h_set,
                              input bit cut);
    int unsigned wd;
    int unsigned ht;
    int unsigned total;
    int unsigned stop;
    in_item_t    it;
    wd    = (w_set == 0) ? 1 : ((w_set > MaxWidthDef) ? MaxWidthDef : w_set);
    ht    = (h_set == 0) ? 1 : ((h_set > MaxHeightDef) ? MaxHeightDef : h_set);
    total = wd*ht + wd + 1;
    stop  = cut ? $urandom_range((total > CutMax) ? CutMax : total - 1, 1) : total;
    for (int n = 0; n < stop; n++) begin
      it = mk_item(1'b0, pick_sample(), pick_sample(), pick_sample());
      if (n >= wd*ht) it.req_type = ($urandom_range(3) != 0);
      else if (n != 0) it.req_type = ($urandom_range(15) == 0);
      send_pixel(it);
    end
    // stray drain with no frame open
    if (!cut && $urandom_range(3) == 0)
      send_pixel(mk_item(1'b1, pick_sample(), pick_sample(), pick_sample()));
  endtask

  // receiver: random stalls, plus a long hold whenever one is asked for
  initial begin : receiver
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    blur_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        blur_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_seen != hold_asked) begin
        hold_seen++;
        hold_left = HoldCycles;
        blur_ch.ready <= 1'b0;
      end else begin
        blur_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // stimulus and verdict
  initial begin : stimulus
    int unsigned w;
    int unsigned h;
    bit          pk;
    int          nfr;
    bit          big;
    cfg_we       <= 1'b0;
    cfg_idx      <= CfgFrameWidth;
    cfg_data     <= '0;
    pix_ch.valid <= 1'b0;
    pix_ch.data  <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset sizes: one-pixel frame, idle drains around it, a pixel past the frame
    send_pixel(mk_item(1'b1, 8'h00, 8'h00, 8'h00));
    send_pixel(mk_item(1'b0, 8'hFF, 8'hFF, 8'hFF));
    send_pixel(mk_item(1'b0, 8'h5A, 8'hFF, 8'hFF));
    send_pixel(mk_item(1'b1, 8'h00, 8'h00, 8'h00));
    send_pixel(mk_item(1'b1, 8'hFF, 8'hFF, 8'hFF));
    finish_phase();

    // packed 3x3 with a drain inside the frame and a pixel among the trailing drains
    program_frame(3, 3, 1'b1);
    for (int n = 0; n < 13; n++) begin
      send_pixel(mk_item(n == 4 || (n >= 9 && n != 10), 8'hFF,
                         (n % 2 != 0) ? 8'hFF : 8'h00, 8'(n*20)));
    end
    finish_phase();

    // single lane with the other lanes full: they must read as zero
    program_frame(2, 1, 1'b0);
    for (int n = 0; n < 5; n++) begin
      send_pixel(mk_item(n >= 2 && n != 3, 8'(255 - n), 8'hFF, 8'hFF));
    end
    finish_phase();

    // random frames, with the extreme sizes placed among them
    for (int p = 0; p < 14; p++) begin
      if (p == 5) begin
        tx_idle_pct = 58;
        rx_idle_pct = 12;
      end else if (p == 10) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      case (p)
        2: begin
          w = 2047; h = 2047; pk = 1'b1;
        end
        7: begin
          w = 0; h = 0; pk = 1'b1;
        end
        11: begin
          w = 1; h = 2047; pk = 1'b0;
        end
        default: begin
          w  = $urandom_range(10, 1);
          h  = $urandom_range(5, 1);
          pk = $urandom_range(1);
        end
      endcase
      program_frame(w, h, pk);
      // stall the output long enough to back up the input
      if (p % 5 == 3) hold_asked <= hold_asked + 1;
      // oversized frames only get a cut-off prefix
      big = (w > 10 || h > 5);
      nfr = big ? 1 : $urandom_range(2, 1);
      for (int f = 0; f < nfr; f++) begin
        stream_frame(w, h, f == nfr - 1 && (big || $urandom_range(3) == 0));
      end
      finish_phase();
    end

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // hard stop, far beyond the slowest passing run
  initial begin : watchdog
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

/* gaussian_blur_3x3_top.f */
+incdir+rtl
rtl/gb3_pkg.sv
rtl/gb3_stream_if.sv
rtl/gb3_line_buf.sv
rtl/gb3_window.sv
rtl/gb3_blur.sv
rtl/gaussian_blur_3x3_top.sv
verif/gaussian_blur_3x3_checker.sv
verif/gaussian_blur_3x3_top_tb.sv
